[rtl/core/flash_command_controller_top_macros.svh]
// Assertion macros shared by the flash command controller modules.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef FLASH_COMMAND_CONTROLLER_TOP_MACROS_SVH
`define FLASH_COMMAND_CONTROLLER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fcc assertion failed");
`define FCC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fcc forbidden condition seen");
`else
`define FCC_ASSERT(lbl, clk, rst, prop)
`define FCC_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/core/fcc_pkg.sv]
// Package for the flash command controller: sizes, command codes, register
// indexes, state and command types. Depends on nothing.
`default_nettype none
package fcc_pkg;

   localparam int BankBytes   = 65536;
   localparam int MaxBanks    = 2;
   localparam int SectorBytes = 4096;
   localparam int WindowBytes = 65536;
   localparam int StoreBytes  = MaxBanks * BankBytes;
   localparam int AddrW       = $clog2(StoreBytes);
   localparam int IdxW        = $clog2(StoreBytes + WindowBytes);
   localparam int OffsetW     = 16;
   localparam int ByteW       = 8;
   localparam int BankCountW  = 2;
   localparam int CsrIndexW   = 2;
   localparam int CsrDataW    = 8;
   localparam int QDepth      = 2;
   localparam int QPtrW       = $clog2(QDepth);
   localparam int QCountW     = $clog2(QDepth + 1);

   localparam logic [OffsetW-1:0] ADDR_UNLOCK1 = 16'h5555;
   localparam logic [OffsetW-1:0] ADDR_UNLOCK2 = 16'h2AAA;
   localparam logic [OffsetW-1:0] SECTOR_MASK  = 16'hF000;
   localparam logic [OffsetW-1:0] ID_MAKER_OFFSET  = 16'h0000;
   localparam logic [OffsetW-1:0] ID_DEVICE_OFFSET = 16'h0001;

   localparam logic [ByteW-1:0] CMD_UNLOCK1      = 8'hAA;
   localparam logic [ByteW-1:0] CMD_UNLOCK2      = 8'h55;
   localparam logic [ByteW-1:0] CMD_ID_MODE      = 8'h90;
   localparam logic [ByteW-1:0] CMD_PROGRAM      = 8'hA0;
   localparam logic [ByteW-1:0] CMD_BANK_SELECT  = 8'hB0;
   localparam logic [ByteW-1:0] CMD_ERASE        = 8'h80;
   localparam logic [ByteW-1:0] CMD_CHIP_ERASE   = 8'h10;
   localparam logic [ByteW-1:0] CMD_SECTOR_ERASE = 8'h30;
   localparam logic [ByteW-1:0] CMD_RESET        = 8'hF0;
   localparam logic [ByteW-1:0] ERASED_BYTE      = 8'hFF;

   localparam logic [CsrIndexW-1:0] REG_DEVICE_ENABLE = 2'd0;
   localparam logic [CsrIndexW-1:0] REG_BANK_COUNT    = 2'd1;
   localparam logic [CsrIndexW-1:0] REG_MAKER_ID      = 2'd2;
   localparam logic [CsrIndexW-1:0] REG_DEVICE_ID     = 2'd3;

   localparam logic                  DEVICE_ENABLE_RESET = 1'b1;
   localparam logic [BankCountW-1:0] BANK_COUNT_RESET    = 2'd2;
   localparam logic [ByteW-1:0]      MAKER_ID_RESET      = 8'hC2;
   localparam logic [ByteW-1:0]      DEVICE_ID_RESET     = 8'h09;

   typedef enum logic [2:0] {
      PH_IDLE, PH_UNL1, PH_UNL2, PH_PROG, PH_BANK, PH_ERA0, PH_ERA1, PH_ERA2
   } phase_type;

   typedef enum logic [2:0] {
      OP_REPLY, OP_READ, OP_PROG, OP_CHIP, OP_SECT, OP_MARK
   } op_type;

   typedef enum logic [2:0] {
      BK_CLEAR, BK_IDLE, BK_READ, BK_PROG, BK_ERASE
   } bk_state_type;

   typedef struct packed {
      op_type           op;
      logic [AddrW-1:0] addr;
      logic [ByteW-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

[rtl/core/fcc_req_if.sv]
// Request channel of the flash command controller: valid, ready and one access.
// Depends on nothing.
`default_nettype none
interface fcc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] offset;
   logic [7:0]  write_byte;

   modport source (output valid, output func, output offset, output write_byte,
                   input ready);
   modport sink (input valid, input func, input offset, input write_byte,
                 output ready);
endinterface
`default_nettype wire

[rtl/core/fcc_rsp_if.sv]
// Response channel of the flash command controller: valid, ready and one result.
// Depends on nothing.
`default_nettype none
interface fcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       modified;

   modport source (output valid, output read_byte, output modified, input ready);
   modport sink (input valid, input read_byte, input modified, output ready);
endinterface
`default_nettype wire

[rtl/core/fcc_front.sv]
// Front end: accepts accesses, holds the registers and the unlock command
// sequencer, and turns each access into a store command. Uses fcc_pkg, fcc_req_if.
`default_nettype none
module fcc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   fcc_req_if.sink                            req,
   input  wire logic                          csr_we,
   input  wire logic [fcc_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [fcc_pkg::CsrDataW-1:0]  csr_wdata,
   input  wire logic                          init_busy,
   input  wire fcc_pkg::q_status_type         q_status,
   output logic                               push,
   output fcc_pkg::cmd_type                   push_cmd
);

   fcc_pkg::phase_type phase_ff, phase_in;
   logic id_mode_ff, id_mode_in;
   logic bank_ff, bank_in;

   logic                              enable_ff;
   logic [fcc_pkg::BankCountW-1:0]    bank_count_ff;
   logic [fcc_pkg::ByteW-1:0]         maker_ff;
   logic [fcc_pkg::ByteW-1:0]         device_ff;

   logic                           accept;
   logic [fcc_pkg::BankCountW-1:0] eff_banks;
   logic [fcc_pkg::BankCountW-1:0] eff_banks_m1;
   logic [fcc_pkg::IdxW-1:0]       used_bytes;
   logic [fcc_pkg::IdxW-1:0]       bank_base;
   logic [fcc_pkg::IdxW-1:0]       cell_idx;
   logic [fcc_pkg::IdxW-1:0]       sect_idx;
   logic                           cell_ok;
   logic                           sect_ok;

   assign req.ready = !q_status.full && !init_busy;
   assign accept    = req.valid && req.ready;
   assign push      = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= fcc_pkg::DEVICE_ENABLE_RESET;
         bank_count_ff <= fcc_pkg::BANK_COUNT_RESET;
         maker_ff      <= fcc_pkg::MAKER_ID_RESET;
         device_ff     <= fcc_pkg::DEVICE_ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fcc_pkg::REG_DEVICE_ENABLE: enable_ff     <= csr_wdata[0];
            fcc_pkg::REG_BANK_COUNT:    bank_count_ff <= csr_wdata[fcc_pkg::BankCountW-1:0];
            fcc_pkg::REG_MAKER_ID:      maker_ff      <= csr_wdata;
            fcc_pkg::REG_DEVICE_ID:     device_ff     <= csr_wdata;
            default:                    enable_ff     <= enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fcc_pkg::PH_IDLE;
         id_mode_ff <= 1'b0;
         bank_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         id_mode_ff <= id_mode_in;
         bank_ff    <= bank_in;
      end
   end

   always_comb begin
      if (bank_count_ff == '0) begin
         eff_banks = fcc_pkg::BankCountW'(1);
      end else if (bank_count_ff > fcc_pkg::BankCountW'(fcc_pkg::MaxBanks)) begin
         eff_banks = fcc_pkg::BankCountW'(fcc_pkg::MaxBanks);
      end else begin
         eff_banks = bank_count_ff;
      end
      eff_banks_m1 = eff_banks - fcc_pkg::BankCountW'(1);
      used_bytes = fcc_pkg::IdxW'(eff_banks) * fcc_pkg::IdxW'(fcc_pkg::BankBytes);
      bank_base  = bank_ff ? fcc_pkg::IdxW'(fcc_pkg::BankBytes) : '0;
      cell_idx   = bank_base + fcc_pkg::IdxW'(req.offset);
      sect_idx   = bank_base + fcc_pkg::IdxW'(req.offset & fcc_pkg::SECTOR_MASK);
      cell_ok    = (cell_idx < used_bytes)
                   && (cell_idx < fcc_pkg::IdxW'(fcc_pkg::StoreBytes));
      sect_ok    = (sect_idx < used_bytes)
                   && (sect_idx < fcc_pkg::IdxW'(fcc_pkg::StoreBytes));

      phase_in      = phase_ff;
      id_mode_in    = id_mode_ff;
      bank_in       = bank_ff;
      push_cmd.op   = fcc_pkg::OP_REPLY;
      push_cmd.addr = cell_idx[fcc_pkg::AddrW-1:0];
      push_cmd.data = fcc_pkg::ERASED_BYTE;

      if (!enable_ff) begin
         push_cmd.op = fcc_pkg::OP_REPLY;
      end else if (!req.func) begin
         if (id_mode_ff) begin
            if (req.offset == fcc_pkg::ID_MAKER_OFFSET) begin
               push_cmd.data = maker_ff;
            end else if (req.offset == fcc_pkg::ID_DEVICE_OFFSET) begin
               push_cmd.data = device_ff;
            end
         end else if (cell_ok) begin
            push_cmd.op = fcc_pkg::OP_READ;
         end
      end else if (req.write_byte == fcc_pkg::CMD_RESET && phase_ff != fcc_pkg::PH_PROG) begin
         id_mode_in = 1'b0;
         phase_in   = fcc_pkg::PH_IDLE;
      end else begin
         unique case (phase_ff)
            fcc_pkg::PH_IDLE: begin
               if (req.offset == fcc_pkg::ADDR_UNLOCK1
                   && req.write_byte == fcc_pkg::CMD_UNLOCK1) begin
                  phase_in = fcc_pkg::PH_UNL1;
               end
            end
            fcc_pkg::PH_UNL1: begin
               phase_in = (req.offset == fcc_pkg::ADDR_UNLOCK2
                           && req.write_byte == fcc_pkg::CMD_UNLOCK2)
                          ? fcc_pkg::PH_UNL2 : fcc_pkg::PH_IDLE;
            end
            fcc_pkg::PH_UNL2: begin
               phase_in = fcc_pkg::PH_IDLE;
               if (req.offset == fcc_pkg::ADDR_UNLOCK1) begin
                  priority if (req.write_byte == fcc_pkg::CMD_ID_MODE) begin
                     id_mode_in = 1'b1;
                  end else if (req.write_byte == fcc_pkg::CMD_PROGRAM) begin
                     phase_in = fcc_pkg::PH_PROG;
                  end else if (req.write_byte == fcc_pkg::CMD_BANK_SELECT) begin
                     phase_in = fcc_pkg::PH_BANK;
                  end else if (req.write_byte == fcc_pkg::CMD_ERASE) begin
                     phase_in = fcc_pkg::PH_ERA0;
                  end else begin
                     phase_in = fcc_pkg::PH_IDLE;
                  end
               end
            end
            fcc_pkg::PH_ERA0: begin
               phase_in = (req.offset == fcc_pkg::ADDR_UNLOCK1
                           && req.write_byte == fcc_pkg::CMD_UNLOCK1)
                          ? fcc_pkg::PH_ERA1 : fcc_pkg::PH_IDLE;
            end
            fcc_pkg::PH_ERA1: begin
               phase_in = (req.offset == fcc_pkg::ADDR_UNLOCK2
                           && req.write_byte == fcc_pkg::CMD_UNLOCK2)
                          ? fcc_pkg::PH_ERA2 : fcc_pkg::PH_IDLE;
            end
            fcc_pkg::PH_ERA2: begin
               phase_in = fcc_pkg::PH_IDLE;
               if (req.offset == fcc_pkg::ADDR_UNLOCK1
                   && req.write_byte == fcc_pkg::CMD_CHIP_ERASE) begin
                  push_cmd.op = fcc_pkg::OP_CHIP;
               end else if (req.write_byte == fcc_pkg::CMD_SECTOR_ERASE) begin
                  push_cmd.op   = sect_ok ? fcc_pkg::OP_SECT : fcc_pkg::OP_MARK;
                  push_cmd.addr = sect_idx[fcc_pkg::AddrW-1:0];
               end
            end
            fcc_pkg::PH_PROG: begin
               phase_in = fcc_pkg::PH_IDLE;
               if (cell_ok) begin
                  push_cmd.op   = fcc_pkg::OP_PROG;
                  push_cmd.data = req.write_byte;
               end
            end
            fcc_pkg::PH_BANK: begin
               phase_in = fcc_pkg::PH_IDLE;
               bank_in  = (eff_banks > fcc_pkg::BankCountW'(1))
                          ? (req.write_byte[0] & eff_banks_m1[0]) : 1'b0;
            end
            default: phase_in = fcc_pkg::PH_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/core/fcc_queue.sv]
// Short command queue between the front end and the store engine.
// Uses fcc_pkg and the assertion macros.
`default_nettype none
`include "flash_command_controller_top_macros.svh"
module fcc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fcc_pkg::cmd_type   push_cmd,
   input  wire logic               pop,
   output fcc_pkg::q_status_type   q_status,
   output fcc_pkg::cmd_type        head
);

   fcc_pkg::cmd_type entry_ff [fcc_pkg::QDepth];
   logic [fcc_pkg::QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [fcc_pkg::QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [fcc_pkg::QCountW-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == fcc_pkg::QCountW'(fcc_pkg::QDepth));
   assign q_status.empty = (count_ff == '0);
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fcc_pkg::QPtrW'(fcc_pkg::QDepth - 1))
                     ? '0 : wr_ptr_ff + fcc_pkg::QPtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fcc_pkg::QPtrW'(fcc_pkg::QDepth - 1))
                     ? '0 : rd_ptr_ff + fcc_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + fcc_pkg::QCountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fcc_pkg::QCountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `FCC_NEVER(a_push_when_full, clock, reset, push && q_status.full)
   `FCC_NEVER(a_pop_when_empty, clock, reset, pop && q_status.empty)
   `FCC_ASSERT(a_count_bound, clock, reset, count_ff <= fcc_pkg::QCountW'(fcc_pkg::QDepth))

endmodule
`default_nettype wire

[rtl/core/fcc_back.sv]
// Store engine: owns the byte store, runs reads, programs and erase sweeps,
// keeps the changed flag and drives the response register. Uses fcc_pkg, fcc_rsp_if.
`default_nettype none
`include "flash_command_controller_top_macros.svh"
module fcc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fcc_pkg::q_status_type q_status,
   input  wire fcc_pkg::cmd_type    head,
   output logic                     pop,
   output logic                     init_busy,
   fcc_rsp_if.source                rsp
);

   logic [fcc_pkg::ByteW-1:0] store_mem [fcc_pkg::StoreBytes];

   fcc_pkg::bk_state_type state_ff, state_in;
   logic [fcc_pkg::AddrW-1:0] addr_ff, addr_in;
   logic [fcc_pkg::AddrW-1:0] last_ff, last_in;
   fcc_pkg::cmd_type          cur_ff, cur_in;
   logic                      changed_ff, changed_in;
   logic [fcc_pkg::ByteW-1:0] mem_rdata_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [fcc_pkg::ByteW-1:0] rsp_byte_ff;
   logic                      rsp_mod_ff;

   logic                      out_free;
   logic                      load_out;
   logic [fcc_pkg::ByteW-1:0] out_byte;
   logic                      mem_we;
   logic [fcc_pkg::AddrW-1:0] mem_waddr;
   logic [fcc_pkg::ByteW-1:0] mem_wdata;
   logic [fcc_pkg::AddrW-1:0] mem_raddr;

   assign init_busy     = (state_ff == fcc_pkg::BK_CLEAR);
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_byte = rsp_byte_ff;
   assign rsp.modified  = rsp_mod_ff;
   assign mem_raddr     = head.addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcc_pkg::BK_CLEAR;
         addr_ff      <= '0;
         last_ff      <= fcc_pkg::AddrW'(fcc_pkg::StoreBytes - 1);
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         last_ff      <= last_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load_out) begin
         rsp_byte_ff <= out_byte;
         rsp_mod_ff  <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= store_mem[mem_raddr];
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      last_in    = last_ff;
      cur_in     = cur_ff;
      changed_in = changed_ff;
      pop        = 1'b0;
      load_out   = 1'b0;
      out_byte   = fcc_pkg::ERASED_BYTE;
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = fcc_pkg::ERASED_BYTE;

      unique case (state_ff)
         fcc_pkg::BK_CLEAR, fcc_pkg::BK_ERASE: begin
            mem_we = 1'b1;
            if (addr_ff == last_ff) begin
               state_in = fcc_pkg::BK_IDLE;
            end else begin
               addr_in = addr_ff + fcc_pkg::AddrW'(1);
            end
         end
         fcc_pkg::BK_IDLE: begin
            if (!q_status.empty && out_free) begin
               pop    = 1'b1;
               cur_in = head;
               unique case (head.op)
                  fcc_pkg::OP_REPLY: begin
                     load_out = 1'b1;
                     out_byte = head.data;
                  end
                  fcc_pkg::OP_READ: state_in = fcc_pkg::BK_READ;
                  fcc_pkg::OP_PROG: state_in = fcc_pkg::BK_PROG;
                  fcc_pkg::OP_CHIP: begin
                     changed_in = 1'b1;
                     load_out   = 1'b1;
                     addr_in    = '0;
                     last_in    = fcc_pkg::AddrW'(fcc_pkg::StoreBytes - 1);
                     state_in   = fcc_pkg::BK_ERASE;
                  end
                  fcc_pkg::OP_SECT: begin
                     changed_in = 1'b1;
                     load_out   = 1'b1;
                     addr_in    = head.addr;
                     last_in    = head.addr + fcc_pkg::AddrW'(fcc_pkg::SectorBytes - 1);
                     state_in   = fcc_pkg::BK_ERASE;
                  end
                  fcc_pkg::OP_MARK: begin
                     changed_in = 1'b1;
                     load_out   = 1'b1;
                  end
                  default: load_out = 1'b1;
               endcase
            end
         end
         fcc_pkg::BK_READ: begin
            load_out = 1'b1;
            out_byte = mem_rdata_ff;
            state_in = fcc_pkg::BK_IDLE;
         end
         fcc_pkg::BK_PROG: begin
            if (mem_rdata_ff != cur_ff.data) begin
               mem_we     = 1'b1;
               mem_waddr  = cur_ff.addr;
               mem_wdata  = cur_ff.data;
               changed_in = 1'b1;
            end
            load_out = 1'b1;
            state_in = fcc_pkg::BK_IDLE;
         end
         default: state_in = fcc_pkg::BK_IDLE;
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && !rsp.ready);
   end

   `FCC_ASSERT(a_changed_sticky, clock, reset, !$fell(changed_ff) || $past(reset))
   `FCC_ASSERT(a_sweep_in_bounds, clock, reset, (state_ff == fcc_pkg::BK_ERASE) |-> (addr_ff <= last_ff))
   `FCC_ASSERT(a_out_free_after_pop, clock, reset, (state_ff == fcc_pkg::BK_READ || state_ff == fcc_pkg::BK_PROG) |-> !rsp_valid_ff)

endmodule
`default_nettype wire

[rtl/core/flash_command_controller_top.sv]
// Top level of the flash command controller: front end, command queue and
// store engine. Uses fcc_pkg, fcc_req_if, fcc_rsp_if, fcc_front, fcc_queue, fcc_back.
//
// The request channel carries one bus access per beat (func, offset, write_byte);
// the response channel returns one beat per access (read_byte, modified), in order.
// Registers are written through csr_we, csr_index and csr_wdata; the user must write
// them only while no access is in flight, as the block does not enforce this. They
// take effect on the next access. The store engine takes accesses that need no store
// lookup at one per cycle while rsp_chan.ready is high, and no new access until a
// store read or a program has passed its read or program state. An erase keeps the
// store engine busy while it sweeps the sector or, for a chip erase, the whole store,
// one byte cleared per cycle on the single write port of the store; its response is
// sent at the start of the sweep. Up to two accesses wait in the queue meanwhile.
// After reset the store is swept to 0xFF and req_chan.ready stays low until the sweep
// ends; registers return to their reset values at once. When the receiver holds
// rsp_chan.ready low the result waits in the response register, the queue fills and
// req_chan.ready then drops.
`default_nettype none
module flash_command_controller_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   fcc_req_if.sink                            req_chan,
   fcc_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [fcc_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [fcc_pkg::CsrDataW-1:0]  csr_wdata
);

   logic                  push;
   logic                  pop;
   logic                  init_busy;
   fcc_pkg::cmd_type      push_cmd;
   fcc_pkg::cmd_type      head;
   fcc_pkg::q_status_type q_status;

   fcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .init_busy (init_busy),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   fcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head     (head)
   );

   fcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire
